FILE: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/trpg_pkg.sv
// types and constants for the tile row pixel generator
// no dependencies; imported by every module of the block
package trpg_pkg;

    localparam int NUM_LAYERS  = 4;
    localparam int NUM_PIXELS  = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [2:0]            LAST_COL    = 3'd7;
    localparam logic [NUM_LAYERS-1:0] MODES_RESET = 4'hf;
    localparam logic                  REG_MODES   = 1'b0;

    localparam logic [14:0] PAL4_MASK = 15'h7ff0;
    localparam logic [14:0] PAL8_MASK = 15'h7f00;

    typedef struct packed {
        logic [15:0] tile_word;
        logic [1:0]  layer;
        logic [2:0]  row;
        logic [31:0] pattern_first;
        logic [31:0] pattern_second;
    } in_beat_t;

    typedef struct packed {
        logic [14:0] pixel_index;
        logic [2:0]  column;
        logic [20:0] row_address;
        logic        last;
    } out_beat_t;

    // one decoded tile row, ready for serializing
    typedef struct packed {
        logic [20:0]                 addr;
        logic [14:0]                 pal;
        logic [NUM_PIXELS-1:0][7:0]  pix;
    } row_job_t;

endpackage

FILE: src/tile_row_pixel_generator.sv
// tile row pixel generator: one tile row in, eight palette-index pixel beats out
// a row goes through the input, decode, serializer and output registers in that order
// throughput: one pixel beat per cycle unless the output stalls, set by the serializer
// the input and decode registers let the next row wait while the current one is emitted
// reset: pipeline empties, all layers return to 4-bit mode
module tile_row_pixel_generator
    import trpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data
);

    logic [NUM_LAYERS-1:0] modes;
    logic                  job_valid;
    logic                  job_stall;
    row_job_t              job_data;

    trpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modes   (modes)
    );

    trpg_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .modes     (modes),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .job_data  (job_data)
    );

    trpg_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .job_data  (job_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: src/trpg_regs.sv
// configuration register file: per-layer 4-bit mode bits behind an apb-style port
// depends on trpg_pkg
module trpg_regs
    import trpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [NUM_LAYERS-1:0] modes
);

    logic [NUM_LAYERS-1:0] modes_reg;
    logic [NUM_LAYERS-1:0] modes_next;
    logic                  hit;

    assign hit = (paddr[CFG_ADDR_W-1:2] == REG_MODES);

    always_comb
    begin
        modes_next = modes_reg;
        if (psel && penable && pwrite && hit)
        begin
            modes_next = pwdata[NUM_LAYERS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= MODES_RESET;
        end
        else
        begin
            modes_reg <= modes_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata[NUM_LAYERS-1:0] = modes_reg;
        end
    end

    assign pready = 1'b1;
    assign modes  = modes_reg;

endmodule

FILE: src/trpg_decode.sv
// input register and decode stage: mode lookup, pattern address, palette bits, pixel split
// depends on trpg_pkg
module trpg_decode
    import trpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [NUM_LAYERS-1:0] modes,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  job_valid,
    input  logic                  job_stall,
    output row_job_t              job_data
);

    logic     a_valid_reg;
    logic     a_valid_next;
    in_beat_t a_data_reg;
    logic     a_four_reg;
    logic     a_free;

    logic     b_valid_reg;
    logic     b_valid_next;
    row_job_t b_data_reg;
    row_job_t b_data_next;
    logic     b_load;

    logic [20:0] base;
    logic [20:0] offset;

    // stage b takes a new beat when empty or when its beat moves on
    assign b_load = !b_valid_reg || !job_stall;
    assign a_free = !a_valid_reg || b_load;

    assign a_valid_next = a_free ? in_valid : a_valid_reg;
    assign b_valid_next = b_load ? a_valid_reg : b_valid_reg;

    always_comb
    begin
        base   = {1'b0, a_data_reg.tile_word[13:0], a_data_reg.tile_word[15], 5'b0};
        offset = a_four_reg ? {16'b0, a_data_reg.row, 2'b0} : {15'b0, a_data_reg.row, 3'b0};
        b_data_next.addr = base + offset;
        b_data_next.pal  = a_data_reg.tile_word[14:0] & (a_four_reg ? PAL4_MASK : PAL8_MASK);
        for (int i = 0; i < NUM_PIXELS; i++)
        begin
            if (a_four_reg)
            begin
                b_data_next.pix[i] = {4'b0, a_data_reg.pattern_first[31 - 4*i -: 4]};
            end
            else if (i < NUM_PIXELS / 2)
            begin
                b_data_next.pix[i] = a_data_reg.pattern_first[31 - 8*i -: 8];
            end
            else
            begin
                b_data_next.pix[i] = a_data_reg.pattern_second[63 - 8*i -: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
        begin
            a_data_reg <= in_data;
            a_four_reg <= modes[in_data.layer];
        end
        if (b_load && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign in_stall  = !a_free;
    assign job_valid = b_valid_reg;
    assign job_data  = b_data_reg;

endmodule

FILE: src/trpg_serial.sv
// row serializer and output register: one pixel beat per cycle while the output is not stalled, leftmost first
// depends on trpg_pkg
module trpg_serial
    import trpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_stall,
    input  row_job_t  job_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic      s_valid_reg;
    logic      s_valid_next;
    row_job_t  s_job_reg;
    logic [2:0] col_reg;
    logic [2:0] col_next;

    logic      o_valid_reg;
    logic      o_valid_next;
    out_beat_t o_data_reg;
    out_beat_t o_data_next;

    logic      o_free;
    logic      emit;
    logic      s_free;

    assign o_free = !o_valid_reg || !out_stall;
    assign emit   = s_valid_reg && o_free;
    // the held row is done once its last pixel moves to the output register
    assign s_free = !s_valid_reg || (emit && col_reg == LAST_COL);

    assign s_valid_next = s_free ? job_valid : s_valid_reg;
    assign o_valid_next = o_free ? s_valid_reg : o_valid_reg;

    always_comb
    begin
        if (s_free)
        begin
            col_next = '0;
        end
        else if (emit)
        begin
            col_next = col_reg + 3'd1;
        end
        else
        begin
            col_next = col_reg;
        end
    end

    always_comb
    begin
        o_data_next.pixel_index = {7'b0, s_job_reg.pix[col_reg]} | s_job_reg.pal;
        o_data_next.column      = col_reg;
        o_data_next.row_address = s_job_reg.addr;
        o_data_next.last        = (col_reg == LAST_COL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            col_reg     <= '0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
            col_reg     <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_free && job_valid)
        begin
            s_job_reg <= job_data;
        end
        if (emit)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign job_stall = !s_free;
    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

FILE: src/trpg_checker.sv
// port-level checker for the tile row pixel generator, bound to the top level
// depends on trpg_pkg and assert_macros.svh
`include "assert_macros.svh"

module trpg_checker
    import trpg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);

    // a stalled beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled output beat changed")

    `ASSERT_IMPLIES(a_last_col, clk, rst_n, out_valid, out_data.last == (out_data.column == LAST_COL), "last flag does not match column")

    // pixels of a row leave back to back with the same address
    `ASSERT_NEXT(a_col_step, clk, rst_n, out_valid && !out_stall && !out_data.last, out_valid && out_data.column == 3'($past(out_data.column) + 3'd1) && out_data.row_address == $past(out_data.row_address), "row beats not contiguous")

    `ASSERT_NEXT(a_row_start, clk, rst_n, out_valid && !out_stall && out_data.last, !out_valid || out_data.column == 3'd0, "row does not start at column zero")

endmodule

bind tile_row_pixel_generator trpg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
